@@ hdl/srfp_pkg.sv @@
`default_nettype none

package srfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    localparam logic [3:0] RUN_LENGTH_RST  = 4'd5;
    localparam logic [7:0] SYNC_BIG_RST    = 8'h5A;
    localparam logic [7:0] SYNC_LITTLE_RST = 8'hA5;

    typedef enum logic [1:0] {
        CFG_RUN_LENGTH  = 2'd0,
        CFG_SYNC_BIG    = 2'd1,
        CFG_SYNC_LITTLE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_PAYLOAD = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_SUM_ERR = 2'd2,
        STATUS_LEN_ERR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_SUM,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic    hunt_step;
        logic    len_load;
        logic    pay_step;
        logic    rd_issue;
        logic    idx_inc;
        logic    out_load;
        status_t out_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hunt_done;
        logic len_too_big;
        logic len_zero;
        logic pay_done;
        logic sum_ok;
        logic frame_empty;
        logic dump_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/srfp_byte_if.sv @@
`default_nettype none

interface srfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/srfp_result_if.sv @@
`default_nettype none

interface srfp_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       big_endian;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output payload_byte, output byte_index,
                    output big_endian, output status, output last, input ready);
    modport sink (input valid, input payload_byte, input byte_index,
                  input big_endian, input status, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/srfp_cfg_if.sv @@
`default_nettype none

interface srfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/srfp_ram.sv @@
`default_nettype none

module srfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/srfp_ctrl.sv @@
`default_nettype none

module srfp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rx_valid,
    output logic                      rx_ready,
    input  wire srfp_pkg::dp_stat_t   stat,
    output srfp_pkg::ctrl_cmd_t       cmd
);

    srfp_pkg::state_t state_reg;
    srfp_pkg::state_t state_next;
    logic             rx_acc;

    always_comb
    begin
        unique case (state_reg)
            srfp_pkg::ST_HUNT:    rx_ready = 1'b1;
            srfp_pkg::ST_PAYLOAD: rx_ready = 1'b1;
            srfp_pkg::ST_LENGTH:  rx_ready = stat.out_free;
            srfp_pkg::ST_SUM:     rx_ready = stat.out_free;
            default:              rx_ready = 1'b0;
        endcase
    end

    assign rx_acc = rx_valid && rx_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srfp_pkg::ST_HUNT:
            begin
                if (rx_acc && stat.hunt_done)
                begin
                    state_next = srfp_pkg::ST_LENGTH;
                end
            end
            srfp_pkg::ST_LENGTH:
            begin
                if (rx_acc)
                begin
                    priority if (stat.len_too_big)
                        state_next = srfp_pkg::ST_HUNT;
                    else if (stat.len_zero)
                        state_next = srfp_pkg::ST_SUM;
                    else
                        state_next = srfp_pkg::ST_PAYLOAD;
                end
            end
            srfp_pkg::ST_PAYLOAD:
            begin
                if (rx_acc && stat.pay_done)
                begin
                    state_next = srfp_pkg::ST_SUM;
                end
            end
            srfp_pkg::ST_SUM:
            begin
                if (rx_acc)
                begin
                    if (stat.sum_ok && !stat.frame_empty)
                        state_next = srfp_pkg::ST_READ;
                    else
                        state_next = srfp_pkg::ST_HUNT;
                end
            end
            srfp_pkg::ST_READ:
            begin
                state_next = srfp_pkg::ST_LOAD;
            end
            srfp_pkg::ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.dump_last ? srfp_pkg::ST_HUNT : srfp_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = srfp_pkg::ST_HUNT;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.out_status = srfp_pkg::STATUS_PAYLOAD;
        unique case (state_reg)
            srfp_pkg::ST_HUNT:
            begin
                cmd.hunt_step = rx_acc;
            end
            srfp_pkg::ST_LENGTH:
            begin
                cmd.len_load   = rx_acc && !stat.len_too_big;
                cmd.out_load   = rx_acc && stat.len_too_big;
                cmd.out_status = srfp_pkg::STATUS_LEN_ERR;
            end
            srfp_pkg::ST_PAYLOAD:
            begin
                cmd.pay_step = rx_acc;
            end
            srfp_pkg::ST_SUM:
            begin
                // a good non-empty frame is dumped from the store instead
                cmd.out_load   = rx_acc && !(stat.sum_ok && !stat.frame_empty);
                cmd.out_status = stat.sum_ok ? srfp_pkg::STATUS_EMPTY
                                             : srfp_pkg::STATUS_SUM_ERR;
            end
            srfp_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            srfp_pkg::ST_LOAD:
            begin
                cmd.out_load = stat.out_free;
                cmd.idx_inc  = stat.out_free && !stat.dump_last;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srfp_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded into an occupied output register");

    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srfp_pkg::ST_READ |=> state_reg == srfp_pkg::ST_LOAD)
        else $error("store read not followed by result load");

    a_no_take_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srfp_pkg::ST_READ || state_reg == srfp_pkg::ST_LOAD) |-> !rx_ready)
        else $error("byte taken while dumping a frame");
`endif

endmodule

`default_nettype wire

@@ hdl/srfp_datapath.sv @@
`default_nettype none

module srfp_datapath #(
    parameter int MAX_PAYLOAD = srfp_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          rx_byte,
    input  wire srfp_pkg::ctrl_cmd_t cmd,
    output srfp_pkg::dp_stat_t       stat,
    srfp_cfg_if.sink                 cfg,
    srfp_result_if.source            frame
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);

    logic [3:0]       run_len_reg;
    logic [7:0]       sync_big_reg;
    logic [7:0]       sync_little_reg;

    logic [3:0]       sync_count_reg;
    logic [7:0]       prev_byte_reg;
    logic             big_endian_reg;
    logic [LEN_W-1:0] frame_len_reg;
    logic [LEN_W-1:0] rx_count_reg;
    logic [7:0]       sum_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [7:0]       out_byte_reg;
    logic [4:0]       out_index_reg;
    logic             out_big_reg;
    srfp_pkg::status_t out_status_reg;
    logic             out_last_reg;

    logic             is_sync;
    logic             run_hit;
    logic [3:0]       count_inc;
    logic [LEN_W-1:0] rx_count_inc;
    logic [LEN_W-1:0] rd_idx_inc;
    logic [7:0]       ram_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg     <= srfp_pkg::RUN_LENGTH_RST;
            sync_big_reg    <= srfp_pkg::SYNC_BIG_RST;
            sync_little_reg <= srfp_pkg::SYNC_LITTLE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                srfp_pkg::CFG_RUN_LENGTH:  run_len_reg     <= cfg.data[3:0];
                srfp_pkg::CFG_SYNC_BIG:    sync_big_reg    <= cfg.data;
                srfp_pkg::CFG_SYNC_LITTLE: sync_little_reg <= cfg.data;
                default:                   run_len_reg     <= run_len_reg;
            endcase
        end
    end

    // a run grows on a sync byte when empty or when it repeats the last byte
    assign is_sync      = (rx_byte == sync_big_reg) || (rx_byte == sync_little_reg);
    assign run_hit      = is_sync && ((sync_count_reg == 4'd0) || (rx_byte == prev_byte_reg));
    assign count_inc    = sync_count_reg + 4'd1;
    assign rx_count_inc = rx_count_reg + 1'b1;
    assign rd_idx_inc   = LEN_W'(rd_idx_reg) + 1'b1;

    assign stat.hunt_done   = run_hit && ((count_inc >= run_len_reg) || (count_inc == 4'd0));
    assign stat.len_too_big = rx_byte > 8'(MAX_PAYLOAD);
    assign stat.len_zero    = rx_byte == 8'd0;
    assign stat.pay_done    = rx_count_inc >= frame_len_reg;
    assign stat.sum_ok      = sum_reg == rx_byte;
    assign stat.frame_empty = frame_len_reg == '0;
    assign stat.dump_last   = rd_idx_inc == frame_len_reg;
    assign stat.out_free    = !out_valid_reg || frame.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_count_reg <= '0;
            prev_byte_reg  <= '0;
            big_endian_reg <= 1'b0;
            frame_len_reg  <= '0;
            rx_count_reg   <= '0;
            sum_reg        <= '0;
            rd_idx_reg     <= '0;
        end
        else
        begin
            if (cmd.hunt_step)
            begin
                prev_byte_reg <= rx_byte;
                if (run_hit && !stat.hunt_done)
                begin
                    sync_count_reg <= count_inc;
                end
                else
                begin
                    sync_count_reg <= '0;
                end
                if (stat.hunt_done)
                begin
                    big_endian_reg <= rx_byte == sync_big_reg;
                end
            end
            if (cmd.len_load)
            begin
                frame_len_reg <= LEN_W'(rx_byte);
                rx_count_reg  <= '0;
                sum_reg       <= '0;
                rd_idx_reg    <= '0;
            end
            if (cmd.pay_step)
            begin
                rx_count_reg <= rx_count_inc;
                sum_reg      <= sum_reg + rx_byte;
            end
            if (cmd.idx_inc)
            begin
                rd_idx_reg <= rd_idx_inc[ADDR_W-1:0];
            end
        end
    end

    srfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.pay_step),
        .wr_addr (rx_count_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (frame.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_big_reg    <= big_endian_reg;
            out_status_reg <= cmd.out_status;
            if (cmd.out_status == srfp_pkg::STATUS_PAYLOAD)
            begin
                out_byte_reg  <= ram_rdata;
                out_index_reg <= 5'(rd_idx_reg);
                out_last_reg  <= stat.dump_last;
            end
            else
            begin
                out_byte_reg  <= 8'd0;
                out_index_reg <= 5'd0;
                out_last_reg  <= 1'b1;
            end
        end
    end

    assign frame.valid        = out_valid_reg;
    assign frame.payload_byte = out_byte_reg;
    assign frame.byte_index   = out_index_reg;
    assign frame.big_endian   = out_big_reg;
    assign frame.status       = out_status_reg;
    assign frame.last         = out_last_reg;

`ifndef SYNTHESIS
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pay_step |-> rx_count_reg < frame_len_reg)
        else $error("payload write beyond frame length");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> LEN_W'(rd_idx_reg) < frame_len_reg)
        else $error("store read beyond frame length");

    a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.len_load |-> !stat.len_too_big)
        else $error("oversized length loaded");
`endif

endmodule

`default_nettype wire

@@ hdl/sync_run_frame_parser_top.sv @@
// Serial frame parser with an 8-bit payload sum.
// Channels: rx carries one received byte per transfer; frame carries one
// result per transfer (payload byte, index, byte order, status, last); cfg
// writes the run length (index 0) and the two sync values (1 and 2) and is
// always ready. Write configuration only while no frame is in progress.
// A checksum byte that closes a good non-empty frame starts a dump of the
// payload store: each result takes a store read, then an output load, and
// the following read waits for that load; input is held off until the dump
// ends. Error and empty-frame results are loaded into the output register
// at the edge that takes the closing byte.
// The output register takes a new result in the cycle the old one transfers.
// While the receiver stalls, the dump pauses and the length and checksum
// bytes are held off; sync and payload bytes are still taken.
// Reset clears the frame state and output valid and restores the default
// configuration (run of 5, sync values 0x5A and 0xA5). No clearing pass.
`default_nettype none

module sync_run_frame_parser_top #(
    parameter int MAX_PAYLOAD = srfp_pkg::MAX_PAYLOAD_DEF
) (
    input wire logic      clk,
    input wire logic      rst_n,
    srfp_byte_if.sink     rx,
    srfp_result_if.source frame,
    srfp_cfg_if.sink      cfg
);

    srfp_pkg::ctrl_cmd_t cmd;
    srfp_pkg::dp_stat_t  stat;

    srfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srfp_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (rx.rx_byte),
        .cmd     (cmd),
        .stat    (stat),
        .cfg     (cfg),
        .frame   (frame)
    );

endmodule

`default_nettype wire
